[rtl/core/nsc_pkg.sv]
// nsc_pkg: types, character codes, address patterns and defaults shared by
// the NMEA sentence checker modules. No dependencies.
`default_nettype none
package nsc_pkg;

  localparam int BUFFER_LEN_DEF = 256;
  localparam int MAX_FIELDS_DEF = 32;

  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_IDX_ENABLE = 1'b0;

  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_COMMA  = 8'h2C;
  localparam logic [7:0] OFS_DIGIT  = 8'h30;
  localparam logic [7:0] OFS_UPPER  = 8'h37;
  localparam logic [7:0] OFS_LOWER  = 8'h57;

  localparam logic [39:0] ADDR_GGA = 40'h4750474741;
  localparam logic [39:0] ADDR_GSA = 40'h4750475341;
  localparam logic [39:0] ADDR_RMC = 40'h4750524D43;
  localparam logic [39:0] ADDR_GSV = 40'h4750475356;

  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_GGA   = 3'd1;
  localparam logic [2:0] KIND_GSA   = 3'd2;
  localparam logic [2:0] KIND_RMC   = 3'd3;
  localparam logic [2:0] KIND_GSV   = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_HEX1 = 3'd2,
    PH_HEX2 = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  typedef struct packed {
    logic take;   // parser consumes the held byte this cycle
    logic emit;   // that byte closes a sentence with a result
  } step_ctl_t;

  typedef struct packed {
    logic       checksum_ok;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic       star_missing;
    logic [2:0] sentence_kind;
    logic [5:0] field_count;
    logic [7:0] sentence_length;
  } result_t;

  // Nibble value of a hex digit; bit 4 set flags a non-hex byte.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - OFS_DIGIT;
        hex_nibble = {1'b0, d[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - OFS_UPPER;
        hex_nibble = {1'b0, d[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - OFS_LOWER;
        hex_nibble = {1'b0, d[3:0]};
      end else begin
        hex_nibble = 5'h10;
      end
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/nsc_in_stage.sv]
// nsc_in_stage: input register holding one received byte until the parser
// takes it. Depends on nsc_pkg.
`default_nettype none
module nsc_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_rx_byte,
  input  wire nsc_pkg::step_ctl_t ctl,
  output logic                   hold_valid,
  output logic [7:0]             hold_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || ctl.take;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (ctl.take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule
`default_nettype wire

[rtl/core/nsc_parser.sv]
// nsc_parser: sentence state (phase, running XOR, hex digits, counters,
// address) and the per-byte update and result build. Depends on nsc_pkg.
`default_nettype none
module nsc_parser #(
  parameter int BUFFER_LEN = nsc_pkg::BUFFER_LEN_DEF,
  parameter int MAX_FIELDS = nsc_pkg::MAX_FIELDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               hold_valid,
  input  wire logic [7:0]         hold_byte,
  input  wire logic               process_enable,
  input  wire logic               out_free,
  output nsc_pkg::step_ctl_t      ctl,
  output nsc_pkg::result_t        result
);

  localparam logic [7:0] LenMax   = 8'(BUFFER_LEN - 1);
  localparam logic [5:0] FieldMax = 6'(MAX_FIELDS);

  nsc_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] hex_r, hex_nxt;
  logic       bad_r, bad_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [5:0] comma_r, comma_nxt;
  logic [7:0] addr_r   [5];
  logic [7:0] addr_nxt [5];

  logic [7:0]  c;
  logic [7:0]  pos_inc;
  logic [2:0]  slot;
  logic [4:0]  nib;
  logic [39:0] addr_word;
  logic        emit;
  logic        star_seen;
  logic        hex_short;

  assign c       = hold_byte;
  assign pos_inc = (pos_r < LenMax) ? pos_r + 8'd1 : pos_r;
  assign slot    = pos_inc[2:0] - 3'd1;
  assign nib     = nsc_pkg::hex_nibble(c);

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    hex_nxt   = hex_r;
    bad_nxt   = bad_r;
    pos_nxt   = pos_r;
    comma_nxt = comma_r;
    for (int i = 0; i < 5; i++) begin
      addr_nxt[i] = addr_r[i];
    end
    if (c == nsc_pkg::CHR_DOLLAR) begin
      phase_nxt = nsc_pkg::PH_BODY;
      xor_nxt   = 8'd0;
      hex_nxt   = 8'd0;
      bad_nxt   = 1'b0;
      pos_nxt   = 8'd0;
      comma_nxt = 6'd0;
      for (int i = 0; i < 5; i++) begin
        addr_nxt[i] = 8'd0;
      end
    end else if (phase_r != nsc_pkg::PH_IDLE) begin
      pos_nxt = pos_inc;
      if (pos_inc >= 8'd1 && pos_inc <= 8'd5) begin
        addr_nxt[slot] = c;
      end
      if (c == nsc_pkg::CHR_COMMA && comma_r < FieldMax) begin
        comma_nxt = comma_r + 6'd1;
      end
      if (c == nsc_pkg::CHR_CR) begin
        phase_nxt = nsc_pkg::PH_IDLE;
      end else begin
        unique case (phase_r)
          nsc_pkg::PH_BODY: begin
            if (c == nsc_pkg::CHR_STAR) begin
              phase_nxt = nsc_pkg::PH_HEX1;
            end else begin
              xor_nxt = xor_r ^ c;
            end
          end
          nsc_pkg::PH_HEX1: begin
            hex_nxt   = nib[4] ? 8'd0 : {nib[3:0], 4'd0};
            bad_nxt   = bad_r | nib[4];
            phase_nxt = nsc_pkg::PH_HEX2;
          end
          nsc_pkg::PH_HEX2: begin
            hex_nxt   = nib[4] ? hex_r : {hex_r[7:4], nib[3:0]};
            bad_nxt   = bad_r | nib[4];
            phase_nxt = nsc_pkg::PH_DONE;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  assign emit = hold_valid && (c == nsc_pkg::CHR_CR) && (phase_r != nsc_pkg::PH_IDLE)
                && process_enable;
  // Stall only when a result is due and the output register is still full.
  assign ctl.emit = emit;
  assign ctl.take = hold_valid && (!emit || out_free);

  assign addr_word = {addr_nxt[0], addr_nxt[1], addr_nxt[2], addr_nxt[3], addr_nxt[4]};
  assign star_seen = (phase_r != nsc_pkg::PH_BODY);
  assign hex_short = (phase_r == nsc_pkg::PH_HEX1) || (phase_r == nsc_pkg::PH_HEX2);

  always_comb begin
    result.checksum_ok     = star_seen && !bad_r && !hex_short && (xor_r == hex_r);
    result.computed_sum    = xor_r;
    result.received_sum    = hex_r;
    result.star_missing    = !star_seen;
    result.field_count     = comma_nxt;
    result.sentence_length = pos_nxt;
    priority if (addr_word == nsc_pkg::ADDR_GGA) begin
      result.sentence_kind = nsc_pkg::KIND_GGA;
    end else if (addr_word == nsc_pkg::ADDR_GSA) begin
      result.sentence_kind = nsc_pkg::KIND_GSA;
    end else if (addr_word == nsc_pkg::ADDR_RMC) begin
      result.sentence_kind = nsc_pkg::KIND_RMC;
    end else if (addr_word == nsc_pkg::ADDR_GSV) begin
      result.sentence_kind = nsc_pkg::KIND_GSV;
    end else begin
      result.sentence_kind = nsc_pkg::KIND_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nsc_pkg::PH_IDLE;
      xor_r   <= 8'd0;
      hex_r   <= 8'd0;
      bad_r   <= 1'b0;
      pos_r   <= 8'd0;
      comma_r <= 6'd0;
      for (int i = 0; i < 5; i++) begin
        addr_r[i] <= 8'd0;
      end
    end else if (ctl.take) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      hex_r   <= hex_nxt;
      bad_r   <= bad_nxt;
      pos_r   <= pos_nxt;
      comma_r <= comma_nxt;
      for (int i = 0; i < 5; i++) begin
        addr_r[i] <= addr_nxt[i];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/nsc_out_reg.sv]
// nsc_out_reg: result register; holds one result beat until the sink takes
// it. Depends on nsc_pkg.
`default_nettype none
module nsc_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire nsc_pkg::step_ctl_t  ctl,
  input  wire nsc_pkg::result_t    result,
  output logic                     out_free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output nsc_pkg::result_t         out_data
);

  logic             valid_r, valid_nxt;
  nsc_pkg::result_t data_r;
  logic             load;

  assign out_free  = !valid_r || out_ready;
  assign load      = ctl.take && ctl.emit;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule
`default_nettype wire

[rtl/core/nmea_sentence_checker.sv]
// nmea_sentence_checker: top level; APB enable register, input register,
// parser and result register. Depends on nsc_pkg and the nsc_* modules.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------
//   in      | in_valid/in_ready   | in_rx_byte
//   out     | out_valid/out_ready | checksum_ok, sums, kind, counts, length
//   cfg     | psel/penable/pready | paddr, pwdata, pwrite, prdata
//
// One byte per cycle sustained outside the stall below. A byte waits in the
// input register; the parser updates its state and the result register loads
// on the same edge. A carriage return result is on the out_* ports right after
// the edge at which that byte leaves the input register.
// The only stall is a carriage return meeting a full result register that the
// sink does not read in that cycle; in_ready then stays low until it does.
// Reset is synchronous; afterwards the parser waits for a dollar sign.
`default_nettype none
module nmea_sentence_checker #(
  parameter int BUFFER_LEN = nsc_pkg::BUFFER_LEN_DEF,
  parameter int MAX_FIELDS = nsc_pkg::MAX_FIELDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_checksum_ok,
  output logic [7:0]                         out_computed_sum,
  output logic [7:0]                         out_received_sum,
  output logic                               out_star_missing,
  output logic [2:0]                         out_sentence_kind,
  output logic [5:0]                         out_field_count,
  output logic [7:0]                         out_sentence_length,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nsc_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic               enable_r;
  logic               hold_valid;
  logic [7:0]         hold_byte;
  logic               out_free;
  nsc_pkg::step_ctl_t ctl;
  nsc_pkg::result_t   result;
  nsc_pkg::result_t   out_data;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == nsc_pkg::CFG_IDX_ENABLE);
  assign prdata  = reg_sel ? {31'd0, enable_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      enable_r <= pwdata[0];
    end
  end

  nsc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .ctl        (ctl),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  nsc_parser #(
    .BUFFER_LEN (BUFFER_LEN),
    .MAX_FIELDS (MAX_FIELDS)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .hold_valid     (hold_valid),
    .hold_byte      (hold_byte),
    .process_enable (enable_r),
    .out_free       (out_free),
    .ctl            (ctl),
    .result         (result)
  );

  nsc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_checksum_ok     = out_data.checksum_ok;
  assign out_computed_sum    = out_data.computed_sum;
  assign out_received_sum    = out_data.received_sum;
  assign out_star_missing    = out_data.star_missing;
  assign out_sentence_kind   = out_data.sentence_kind;
  assign out_field_count     = out_data.field_count;
  assign out_sentence_length = out_data.sentence_length;

endmodule
`default_nettype wire

[rtl/core/nsc_checker.sv]
// nsc_checker: port-level assertions for nmea_sentence_checker, bound to the
// top level below. Depends on nsc_pkg.
`default_nettype none
module nsc_checker #(
  parameter int MAX_FIELDS = nsc_pkg::MAX_FIELDS_DEF
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_checksum_ok,
  input wire logic [7:0] out_received_sum,
  input wire logic       out_star_missing,
  input wire logic [2:0] out_sentence_kind,
  input wire logic [5:0] out_field_count,
  input wire logic [7:0] out_sentence_length
);

  localparam logic [5:0] FieldMax = 6'(MAX_FIELDS);

  // a good sum needs a star
  a_ok_has_star: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_checksum_ok |-> !out_star_missing)
    else $error("checksum_ok with star_missing");

  // no star means no digits were read
  a_nostar_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_star_missing |-> out_received_sum == 8'd0)
    else $error("received_sum nonzero without star");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sentence_kind <= nsc_pkg::KIND_GSV) && (out_field_count <= FieldMax))
    else $error("kind or field_count out of range");

  // the carriage return itself is counted
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sentence_length != 8'd0)
    else $error("zero sentence_length");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sentence_length)
      && $stable(out_checksum_ok))
    else $error("result beat dropped or changed while stalled");

endmodule

bind nmea_sentence_checker nsc_checker #(.MAX_FIELDS(MAX_FIELDS)) u_nsc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_checksum_ok     (out_checksum_ok),
  .out_received_sum    (out_received_sum),
  .out_star_missing    (out_star_missing),
  .out_sentence_kind   (out_sentence_kind),
  .out_field_count     (out_field_count),
  .out_sentence_length (out_sentence_length)
);
`default_nettype wire

[tb/tb_nmea_sentence_checker.sv]
// Self-checking bench for nmea_sentence_checker: drives byte streams of NMEA
// sentences, predicts each carriage-return report and compares it per field.
// Depends on nsc_pkg and the nmea_sentence_checker RTL.
`timescale 1ns / 1ps
module tb_nmea_sentence_checker;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;

  // receiver stall patterns
  localparam int SINK_OPEN     = 0;
  localparam int SINK_LIGHT    = 1;
  localparam int SINK_PERIODIC = 2;
  localparam int SINK_HEAVY    = 3;

  // shapes of a random sentence
  localparam int SHAPE_RESTART     = 0;
  localparam int SHAPE_NO_STAR     = 1;
  localparam int SHAPE_STAR_ONLY   = 2;
  localparam int SHAPE_ONE_DIGIT   = 3;
  localparam int SHAPE_JUNK_DIGITS = 4;
  localparam int SHAPE_BAD_SUM     = 5;
  localparam int SHAPE_NO_CR       = 6;
  localparam int SHAPE_TRAILING    = 7;

  localparam logic [nsc_pkg::CFG_ADDR_W-1:0] ENABLE_ADDR = {nsc_pkg::CFG_IDX_ENABLE, 2'b00};

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [7:0]                     in_rx_byte = 8'h00;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_checksum_ok;
  logic [7:0]                     out_computed_sum;
  logic [7:0]                     out_received_sum;
  logic                           out_star_missing;
  logic [2:0]                     out_sentence_kind;
  logic [5:0]                     out_field_count;
  logic [7:0]                     out_sentence_length;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [nsc_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  nmea_sentence_checker dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_checksum_ok     (out_checksum_ok),
    .out_computed_sum    (out_computed_sum),
    .out_received_sum    (out_received_sum),
    .out_star_missing    (out_star_missing),
    .out_sentence_kind   (out_sentence_kind),
    .out_field_count     (out_field_count),
    .out_sentence_length (out_sentence_length),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // sentence tracker state
  nsc_pkg::phase_t s_phase = nsc_pkg::PH_IDLE;
  logic [7:0]      s_xor = '0;
  logic [7:0]      s_hex = '0;
  logic            s_hex_bad = 1'b0;
  logic [7:0]      s_len = '0;
  logic [5:0]      s_commas = '0;
  logic [39:0]     s_addr = '0;
  logic            s_enable = 1'b1;

  nsc_pkg::result_t due_reports[$];

  string address_names[4] = '{"GPGGA", "GPGSA", "GPRMC", "GPGSV"};

  int fail_count = 0;
  int cycle_count = 0;
  int sent_bytes = 0;
  int burst_left = 0;
  int gap_max = 0;
  int sink_mode = SINK_OPEN;
  logic [3:0] stall_tick = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               due_reports.size());
      $display("FAIL nmea_sentence_checker");
      $finish;
    end
  end

  always @(posedge clk) begin
    stall_tick <= stall_tick + 4'd1;
    case (sink_mode)
      SINK_OPEN:     out_ready <= 1'b1;
      SINK_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
      SINK_PERIODIC: out_ready <= (stall_tick >= 4'd11);
      default:       out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic flag(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) flag($sformatf("mismatch %s: expected %02h, got %02h", name, want, got));
  endtask

  always @(posedge clk) begin : result_check
    nsc_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        flag($sformatf("unexpected report: computed %02h received %02h length %0d",
                       out_computed_sum, out_received_sum, out_sentence_length));
      end else begin
        want = due_reports.pop_front();
        check_field("checksum_ok", 8'(want.checksum_ok), 8'(out_checksum_ok));
        check_field("computed_sum", want.computed_sum, out_computed_sum);
        check_field("received_sum", want.received_sum, out_received_sum);
        check_field("star_missing", 8'(want.star_missing), 8'(out_star_missing));
        check_field("sentence_kind", 8'(want.sentence_kind), 8'(out_sentence_kind));
        check_field("field_count", 8'(want.field_count), 8'(out_field_count));
        check_field("sentence_length", want.sentence_length, out_sentence_length);
      end
    end
  end

  // Nibble of a hex digit in either case; bit 4 flags anything else.
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if ((c | 8'h20) >= "a" && (c | 8'h20) <= "f") return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    c = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                     : 8'($urandom_range(8'h20, 8'h7E));
    if (c == nsc_pkg::CHR_DOLLAR || c == nsc_pkg::CHR_STAR || c == nsc_pkg::CHR_CR) c = "N";
    return c;
  endfunction

  // Advance the sentence tracker by one accepted byte; queue a report on CR.
  task automatic follow_byte(input logic [7:0] c);
    logic [4:0]       nib;
    logic             star_seen;
    logic             digits_bad;
    nsc_pkg::result_t r;
    if (c == nsc_pkg::CHR_DOLLAR) begin
      s_phase = nsc_pkg::PH_BODY;
      s_xor = '0;
      s_hex = '0;
      s_hex_bad = 1'b0;
      s_len = '0;
      s_commas = '0;
      s_addr = '0;
    end else if (s_phase != nsc_pkg::PH_IDLE) begin
      if (s_len != 8'(nsc_pkg::BUFFER_LEN_DEF - 1)) s_len++;
      if (s_len >= 1 && s_len <= 5) s_addr[8 * (5 - s_len) +: 8] = c;
      if (c == nsc_pkg::CHR_COMMA && s_commas < 6'(nsc_pkg::MAX_FIELDS_DEF)) s_commas++;
      if (c == nsc_pkg::CHR_CR) begin
        if (s_enable) begin
          star_seen = (s_phase != nsc_pkg::PH_BODY);
          digits_bad = s_hex_bad || s_phase == nsc_pkg::PH_HEX1 || s_phase == nsc_pkg::PH_HEX2;
          r.checksum_ok = star_seen && !digits_bad && s_xor == s_hex;
          r.computed_sum = s_xor;
          r.received_sum = s_hex;
          r.star_missing = !star_seen;
          case (s_addr)
            nsc_pkg::ADDR_GGA: r.sentence_kind = nsc_pkg::KIND_GGA;
            nsc_pkg::ADDR_GSA: r.sentence_kind = nsc_pkg::KIND_GSA;
            nsc_pkg::ADDR_RMC: r.sentence_kind = nsc_pkg::KIND_RMC;
            nsc_pkg::ADDR_GSV: r.sentence_kind = nsc_pkg::KIND_GSV;
            default:           r.sentence_kind = nsc_pkg::KIND_OTHER;
          endcase
          r.field_count = s_commas;
          r.sentence_length = s_len;
          due_reports.push_back(r);
        end
        s_phase = nsc_pkg::PH_IDLE;
      end else begin
        case (s_phase)
          nsc_pkg::PH_BODY: begin
            if (c == nsc_pkg::CHR_STAR) s_phase = nsc_pkg::PH_HEX1;
            else s_xor ^= c;
          end
          nsc_pkg::PH_HEX1: begin
            nib = digit_value(c);
            if (nib[4]) s_hex_bad = 1'b1;
            s_hex = {nib[4] ? 4'h0 : nib[3:0], 4'h0};
            s_phase = nsc_pkg::PH_HEX2;
          end
          nsc_pkg::PH_HEX2: begin
            nib = digit_value(c);
            if (nib[4]) s_hex_bad = 1'b1;
            s_hex[3:0] = nib[4] ? 4'h0 : nib[3:0];
            s_phase = nsc_pkg::PH_DONE;
          end
          default: ;
        endcase
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= c;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
    follow_byte(c);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_hex_tail(input logic [7:0] sum, input bit lower);
    send_byte(nsc_pkg::CHR_STAR);
    send_byte(hex_char(sum[7:4], lower));
    send_byte(hex_char(sum[3:0], lower));
  endtask

  // Send a complete sentence; flip corrupts the transmitted checksum.
  task automatic send_nmea(input string body, input bit lower, input logic [7:0] flip);
    logic [7:0] sum;
    int i;
    sum = 8'h00;
    for (i = 0; i < body.len(); i++) sum ^= body[i];
    send_byte(nsc_pkg::CHR_DOLLAR);
    send_text(body);
    send_hex_tail(sum ^ flip, lower);
    send_byte(nsc_pkg::CHR_CR);
  endtask

  // Drop valid and hold until every report is in and the pipe is empty.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_enable(input logic v);
    logic [31:0] word;
    word = $urandom();
    word[0] = v;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ENABLE_ADDR;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    s_enable = v;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("process_enable readback", {7'd0, v}, {7'd0, prdata[0]});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_sentence();
    logic [7:0] sum;
    logic [7:0] c;
    int shape, pick, hit, n, i;
    bit lower;
    shape = $urandom_range(0, 19);
    pick = $urandom_range(0, 9);
    hit = (pick >= 7) ? $urandom_range(0, 4) : 5;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
    lower = 1'($urandom_range(0, 1));
    sum = 8'h00;
    send_byte(nsc_pkg::CHR_DOLLAR);
    for (i = 0; i < 5; i++) begin
      c = address_names[pick % 4][i];
      if (i == hit) c = body_char();
      send_byte(c);
      sum ^= c;
    end
    for (i = 0; i < n; i++) begin
      c = ($urandom_range(0, 2) == 0) ? nsc_pkg::CHR_COMMA : body_char();
      if (shape == SHAPE_RESTART && i == n / 2) begin
        send_byte(nsc_pkg::CHR_DOLLAR);
        sum = 8'h00;
      end
      send_byte(c);
      sum ^= c;
    end
    case (shape)
      SHAPE_NO_STAR: send_byte(nsc_pkg::CHR_CR);
      SHAPE_STAR_ONLY: begin
        send_byte(nsc_pkg::CHR_STAR);
        send_byte(nsc_pkg::CHR_CR);
      end
      SHAPE_ONE_DIGIT: begin
        send_byte(nsc_pkg::CHR_STAR);
        send_byte(hex_char(sum[7:4], lower));
        send_byte(nsc_pkg::CHR_CR);
      end
      SHAPE_JUNK_DIGITS: begin
        send_byte(nsc_pkg::CHR_STAR);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        send_byte(nsc_pkg::CHR_CR);
      end
      SHAPE_BAD_SUM: begin
        send_hex_tail(sum ^ 8'($urandom_range(1, 255)), lower);
        send_byte(nsc_pkg::CHR_CR);
      end
      SHAPE_NO_CR: send_hex_tail(sum, lower);
      SHAPE_TRAILING: begin
        send_hex_tail(sum, lower);
        repeat ($urandom_range(1, 6)) begin
          send_byte($urandom_range(0, 1) ? nsc_pkg::CHR_COMMA : body_char());
        end
        send_byte(nsc_pkg::CHR_CR);
      end
      default: begin
        send_hex_tail(sum, lower);
        send_byte(nsc_pkg::CHR_CR);
      end
    endcase
  endtask

  // Sentence of exactly span bytes after the dollar, holding a given comma count.
  task automatic long_sentence(input int span, input int commas);
    logic [7:0] sum;
    logic [7:0] c;
    int body_len, left, i;
    body_len = span - 4;
    left = commas;
    sum = 8'h00;
    send_byte(nsc_pkg::CHR_DOLLAR);
    for (i = 0; i < body_len; i++) begin
      if (left > 0 && $urandom_range(0, body_len - i - 1) < left) begin
        c = nsc_pkg::CHR_COMMA;
        left--;
      end else begin
        c = body_char();
      end
      send_byte(c);
      sum ^= c;
    end
    send_hex_tail(sum, 1'($urandom_range(0, 1)));
    send_byte(nsc_pkg::CHR_CR);
  endtask

  task automatic test_directed();
    gap_max = 3;
    sink_mode = SINK_LIGHT;
    send_nmea("GPGGA,1,2", 1'b0, 8'h00);
    send_nmea("GPGSA,,", 1'b1, 8'h00);
    send_nmea("GPRMC,A", 1'b0, 8'h00);
    send_nmea("GPGSV", 1'b1, 8'h00);
    send_nmea("GPXYZ,9", 1'b0, 8'h5A);
    send_text("$*00\r");
    send_text("$GPGGA,1\r");
    // CR before the first and before the second digit
    send_text("$GPRMC*\r");
    send_text("$GPRMC*4\r");
    send_text("$A*G1\r");
    send_text("$A*4g\r");
    send_text("$A**1\r");
    // dollar inside an open sentence restarts it
    send_text("$GP");
    send_nmea("GPGSA,3", 1'b0, 8'h00);
    send_text("$AB*03,x,\r");
    // idle bytes, CR included, are ignored
    send_text("q,*\r7");
    send_text("$\r");
    send_byte(nsc_pkg::CHR_DOLLAR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("*ff\r");
    drain();
  endtask

  task automatic test_enable_off();
    set_enable(1'b0);
    gap_max = 2;
    sink_mode = SINK_OPEN;
    repeat (8) random_sentence();
    send_nmea("GPGGA,5", 1'b0, 8'h00);
    drain();
    set_enable(1'b1);
  endtask

  task automatic test_random(input int n_bytes, input int gaps, input int sink);
    int stop_at;
    gap_max = gaps;
    sink_mode = sink;
    stop_at = sent_bytes + n_bytes;
    while (sent_bytes < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
      random_sentence();
    end
    drain();
  endtask

  task automatic test_saturation();
    gap_max = 1;
    sink_mode = SINK_PERIODIC;
    long_sentence(255, 32);
    long_sentence(300, 40);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_enable(1'b1);
    test_directed();
    test_enable_off();
    test_random(80, 0, SINK_OPEN);
    test_random(80, 6, SINK_LIGHT);
    set_enable(1'b1);
    test_random(80, 2, SINK_PERIODIC);
    test_random(80, 8, SINK_HEAVY);
    test_saturation();
    if (fail_count == 0) begin
      $display("PASS nmea_sentence_checker");
    end else begin
      $display("FAIL nmea_sentence_checker");
    end
    $finish;
  end

endmodule
